### design/page_framebuffer_rect_engine_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the page framebuffer rectangle engine
// Implication checks, same cycle and next cycle, with reset disable.
// ---------------------------------------------------------------------------
`ifndef PAGE_FRAMEBUFFER_RECT_ENGINE_MACROS_SVH
`define PAGE_FRAMEBUFFER_RECT_ENGINE_MACROS_SVH

// antecedent implies consequent in the same cycle
`define PFRE_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication check failed");

// antecedent implies consequent in the next cycle
`define PFRE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication check failed");

`endif

### design/pfre_pkg.sv
// ---------------------------------------------------------------------------
// Page framebuffer rectangle engine package
// Screen geometry, derived widths, command codes and sequencer states.
// ---------------------------------------------------------------------------
package pfre_pkg;

   localparam int SCREEN_COLUMNS = 128;
   localparam int SCREEN_PAGES   = 8;
   localparam int SCREEN_ROWS    = SCREEN_PAGES * 8;
   localparam int STORE_DEPTH    = SCREEN_COLUMNS * SCREEN_PAGES;
   localparam int ADDR_W         = $clog2(STORE_DEPTH);
   localparam int PAGE_W         = (SCREEN_PAGES > 1) ? $clog2(SCREEN_PAGES) : 1;

   localparam logic [8:0] COL_LIMIT = 9'(SCREEN_COLUMNS);
   localparam logic [7:0] ROW_LIMIT = 8'(SCREEN_ROWS);

   localparam logic [2:0] KIND_SET_PIXEL = 3'd0;
   localparam logic [2:0] KIND_CLR_PIXEL = 3'd1;
   localparam logic [2:0] KIND_FILL_RECT = 3'd2;
   localparam logic [2:0] KIND_OUTLINE   = 3'd3;
   localparam logic [2:0] KIND_CLEAR_ALL = 3'd4;
   localparam logic [2:0] KIND_READ_BYTE = 3'd5;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_WALK,
      ST_DRAIN,
      ST_FINISH
   } state_type;

endpackage

### design/page_framebuffer_rect_engine.sv
// ---------------------------------------------------------------------------
// Page framebuffer rectangle engine
// Pixel and rectangle commands walk the clipped columns x pages, clear all
// writes every frame store byte; one transaction at a time, one byte
// read-modify-write per cycle through the single frame store port pair.
// Reset: clearing pass over the frame store, req_ready held low.
// ---------------------------------------------------------------------------
`include "page_framebuffer_rect_engine_macros.svh"

module page_framebuffer_rect_engine
   import pfre_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [2:0] req_kind,
   input  logic [6:0] req_x_pos,
   input  logic [5:0] req_y_pos,
   input  logic [7:0] req_rect_width,
   input  logic [6:0] req_rect_height,
   input  logic [9:0] req_read_address,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_read_data,
   output logic [2:0] rsp_done_kind
);

   state_type state_ff, state_in;
   logic [ADDR_W-1:0] clear_cnt_ff, clear_cnt_in;
   logic notify_ff, notify_in;
   logic pend_valid_ff, pend_valid_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic [2:0] kind_ff, kind_in;
   logic read_sel_ff, read_sel_in;
   logic op_set_ff, op_set_in;
   logic outline_ff, outline_in;
   logic [8:0] x_ff, x_in;
   logic [8:0] xr_ff, xr_in;
   logic [8:0] col_ff, col_in;
   logic [8:0] col_last_ff, col_last_in;
   logic [PAGE_W-1:0] page_ff, page_in;
   logic [PAGE_W-1:0] p0_ff, p0_in;
   logic [PAGE_W-1:0] p1_ff, p1_in;
   logic [7:0] y0_ff, y0_in;
   logic [7:0] y1_ff, y1_in;
   logic [7:0] y1c_ff, y1c_in;
   logic [ADDR_W-1:0] pend_addr_ff, pend_addr_in;
   logic [7:0] pend_mask_ff, pend_mask_in;
   logic [7:0] rsp_data_ff, rsp_data_in;
   logic [2:0] rsp_kind_ff, rsp_kind_in;

   logic accept;
   logic [7:0] w_eff;
   logic [6:0] h_eff;
   logic empty;
   logic [8:0] end_ex;
   logic [7:0] y_end_ex;
   logic [7:0] y1_new;
   logic [7:0] y1c_new;
   logic ra_ok;

   logic [ADDR_W-1:0] walk_addr;
   logic [2:0] lo_bit;
   logic [2:0] hi_bit;
   logic [7:0] range_mask;
   logic [7:0] top_bit;
   logic [7:0] bot_bit;
   logic edge_col;
   logic [7:0] walk_mask;

   logic ram_we;
   logic [ADDR_W-1:0] ram_waddr;
   logic [7:0] ram_wdata;
   logic ram_re;
   logic [ADDR_W-1:0] ram_raddr;
   logic [7:0] ram_rdata;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   // command decode
   always_comb begin
      if (req_kind == KIND_SET_PIXEL || req_kind == KIND_CLR_PIXEL) begin
         w_eff = 8'd1;
         h_eff = 7'd1;
      end else begin
         w_eff = req_rect_width;
         h_eff = req_rect_height;
      end
      empty = (w_eff == 8'd0) || (h_eff == 7'd0) ||
              ({2'b00, req_x_pos} >= COL_LIMIT) || ({2'b00, req_y_pos} >= ROW_LIMIT);
      end_ex   = {2'b00, req_x_pos} + {1'b0, w_eff};
      y_end_ex = {2'b00, req_y_pos} + {1'b0, h_eff};
      y1_new   = y_end_ex - 8'd1;
      y1c_new  = (y1_new >= ROW_LIMIT) ? (ROW_LIMIT - 8'd1) : y1_new;
      ra_ok    = (32'(req_read_address) < 32'(STORE_DEPTH));
   end

   // byte address and pixel mask for the current walk position
   always_comb begin
      walk_addr  = ADDR_W'(32'(page_ff) * 32'(SCREEN_COLUMNS) + 32'(col_ff));
      lo_bit     = (page_ff == p0_ff) ? y0_ff[2:0] : 3'd0;
      hi_bit     = (page_ff == p1_ff) ? y1c_ff[2:0] : 3'd7;
      range_mask = (8'hFF << lo_bit) & (8'hFF >> (3'd7 - hi_bit));
      top_bit    = (page_ff == p0_ff) ? (8'h01 << y0_ff[2:0]) : 8'h00;
      bot_bit    = ((page_ff == p1_ff) && (y1_ff < ROW_LIMIT)) ?
                   (8'h01 << y1_ff[2:0]) : 8'h00;
      edge_col   = (col_ff == x_ff) || (col_ff == xr_ff);
      walk_mask  = (!outline_ff || edge_col) ? range_mask : (top_bit | bot_bit);
   end

   // frame store port control
   always_comb begin
      ram_we    = pend_valid_ff || (state_ff == ST_CLEAR);
      ram_waddr = (state_ff == ST_CLEAR) ? clear_cnt_ff : pend_addr_ff;
      if (state_ff == ST_CLEAR) begin
         ram_wdata = 8'h00;
      end else if (op_set_ff) begin
         ram_wdata = ram_rdata | pend_mask_ff;
      end else begin
         ram_wdata = ram_rdata & ~pend_mask_ff;
      end
      ram_re    = (state_ff == ST_WALK) || (accept && req_kind == KIND_READ_BYTE && ra_ok);
      ram_raddr = (state_ff == ST_WALK) ? walk_addr : ADDR_W'(req_read_address);
   end

   pfre_ram #(
      .WIDTH(8),
      .DEPTH(STORE_DEPTH)
   ) u_frame_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // sequencer
   always_comb begin
      state_in      = state_ff;
      clear_cnt_in  = clear_cnt_ff;
      notify_in     = notify_ff;
      pend_valid_in = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      kind_in       = kind_ff;
      read_sel_in   = read_sel_ff;
      op_set_in     = op_set_ff;
      outline_in    = outline_ff;
      x_in          = x_ff;
      xr_in         = xr_ff;
      col_in        = col_ff;
      col_last_in   = col_last_ff;
      page_in       = page_ff;
      p0_in         = p0_ff;
      p1_in         = p1_ff;
      y0_in         = y0_ff;
      y1_in         = y1_ff;
      y1c_in        = y1c_ff;
      pend_addr_in  = pend_addr_ff;
      pend_mask_in  = pend_mask_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_kind_in   = rsp_kind_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               kind_in     = req_kind;
               read_sel_in = 1'b0;
               op_set_in   = (req_kind != KIND_CLR_PIXEL);
               outline_in  = (req_kind == KIND_OUTLINE);
               x_in        = {2'b00, req_x_pos};
               xr_in       = end_ex - 9'd1;
               col_in      = {2'b00, req_x_pos};
               col_last_in = (end_ex > COL_LIMIT) ? (COL_LIMIT - 9'd1) : (end_ex - 9'd1);
               y0_in       = {2'b00, req_y_pos};
               y1_in       = y1_new;
               y1c_in      = y1c_new;
               p0_in       = PAGE_W'({2'b00, req_y_pos} >> 3);
               page_in     = PAGE_W'({2'b00, req_y_pos} >> 3);
               p1_in       = PAGE_W'(y1c_new >> 3);
               priority case (1'b1)
                  (req_kind == KIND_SET_PIXEL || req_kind == KIND_CLR_PIXEL ||
                   req_kind == KIND_FILL_RECT || req_kind == KIND_OUTLINE): begin
                     state_in = empty ? ST_FINISH : ST_WALK;
                  end
                  (req_kind == KIND_CLEAR_ALL): begin
                     state_in     = ST_CLEAR;
                     clear_cnt_in = '0;
                     notify_in    = 1'b1;
                  end
                  (req_kind == KIND_READ_BYTE): begin
                     state_in    = ST_FINISH;
                     read_sel_in = ra_ok;
                  end
                  default: begin
                     state_in = ST_FINISH;
                  end
               endcase
            end
         end
         ST_CLEAR: begin
            clear_cnt_in = clear_cnt_ff + 1'b1;
            if (32'(clear_cnt_ff) == STORE_DEPTH - 1) begin
               state_in  = notify_ff ? ST_FINISH : ST_IDLE;
               notify_in = 1'b0;
            end
         end
         ST_WALK: begin
            pend_valid_in = 1'b1;
            pend_addr_in  = walk_addr;
            pend_mask_in  = walk_mask;
            if (page_ff == p1_ff) begin
               page_in = p0_ff;
               if (col_ff == col_last_ff) begin
                  state_in = ST_DRAIN;
               end else begin
                  col_in = col_ff + 9'd1;
               end
            end else begin
               page_in = page_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = read_sel_ff ? ram_rdata : 8'h00;
               rsp_kind_in  = kind_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clear_cnt_ff  <= '0;
         notify_ff     <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clear_cnt_ff  <= clear_cnt_in;
         notify_ff     <= notify_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      read_sel_ff  <= read_sel_in;
      op_set_ff    <= op_set_in;
      outline_ff   <= outline_in;
      x_ff         <= x_in;
      xr_ff        <= xr_in;
      col_ff       <= col_in;
      col_last_ff  <= col_last_in;
      page_ff      <= page_in;
      p0_ff        <= p0_in;
      p1_ff        <= p1_in;
      y0_ff        <= y0_in;
      y1_ff        <= y1_in;
      y1c_ff       <= y1c_in;
      pend_addr_ff <= pend_addr_in;
      pend_mask_ff <= pend_mask_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_kind_ff  <= rsp_kind_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;
   assign rsp_done_kind = rsp_kind_ff;

   `PFRE_ASSERT_NEXT(a_busy_after_accept, clock, reset, accept, !req_ready)
   `PFRE_ASSERT_IMP(a_no_write_idle, clock, reset, (state_ff == ST_IDLE), !ram_we)
   `PFRE_ASSERT_IMP(a_clear_writes_zero, clock, reset, (state_ff == ST_CLEAR), (ram_we && ram_wdata == 8'h00))
   `PFRE_ASSERT_IMP(a_no_rw_collision, clock, reset, (ram_we && ram_re), (ram_waddr != ram_raddr))

endmodule

### design/pfre_ram.sv
// ---------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module pfre_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
